// ===== rtl/core/tcw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg
// shared constants and types of the text console writer
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 24;

    localparam int FUNC_W   = 1;
    localparam int CHAR_W   = 8;
    localparam int RROW_W   = 5;
    localparam int RCOL_W   = 7;
    localparam int CURSOR_W = 11;
    localparam int ATTR_W   = 8;

    localparam logic [FUNC_W-1:0] FUNC_WRITE = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 1'b1;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
    localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h07;

    typedef struct packed {
        logic valid;
        logic newline;
    } cursor_cmd_t;

endpackage

// ===== rtl/core/tcw_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_req_if
// request channel: character write or cell read
// ----------------------------------------------------------------------------
interface tcw_req_if;

    logic                          valid;
    logic                          ready;
    logic [tcw_pkg::FUNC_W-1:0]    func;
    logic [tcw_pkg::CHAR_W-1:0]    char_code;
    logic [tcw_pkg::RROW_W-1:0]    read_row;
    logic [tcw_pkg::RCOL_W-1:0]    read_col;

    modport source (output valid, func, char_code, read_row, read_col, input ready);
    modport sink   (input valid, func, char_code, read_row, read_col, output ready);

endinterface

// ===== rtl/core/tcw_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_rsp_if
// response channel: cursor position, read cell and scroll flag
// ----------------------------------------------------------------------------
interface tcw_rsp_if;

    logic                          valid;
    logic                          ready;
    logic [tcw_pkg::CURSOR_W-1:0]  cursor_pos;
    logic [tcw_pkg::CHAR_W-1:0]    cell_char;
    logic [tcw_pkg::ATTR_W-1:0]    cell_attr;
    logic                          scrolled;

    modport source (output valid, cursor_pos, cell_char, cell_attr, scrolled, input ready);
    modport sink   (input valid, cursor_pos, cell_char, cell_attr, scrolled, output ready);

endinterface

// ===== rtl/core/tcw_cfg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_cfg_if
// configuration write channel for the text attribute register
// ----------------------------------------------------------------------------
interface tcw_cfg_if;

    logic                        valid;
    logic                        ready;
    logic [tcw_pkg::ATTR_W-1:0]  data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);

endinterface

// ===== rtl/core/tcw_cursor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_cursor
// cursor row/column/linear tracking and circular top-row pointer
// ----------------------------------------------------------------------------
module tcw_cursor #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF,
    localparam int COL_W  = $clog2(COLUMNS),
    localparam int ROW_W  = $clog2(ROWS),
    localparam int AW     = $clog2(COLUMNS * ROWS)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tcw_pkg::cursor_cmd_t cmd,
    output logic [COL_W-1:0]     cur_col,
    output logic [ROW_W-1:0]     top_row,
    output logic [ROW_W-1:0]     phys_row,
    output logic [AW-1:0]        cur_lin,
    output logic                 will_scroll
);

    logic [ROW_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] top_reg, top_next;
    logic [AW-1:0]    lin_reg, lin_next;

    logic             last_col;
    logic             last_row;
    logic             wraps;
    logic [ROW_W:0]   psum;
    logic [AW:0]      lin_wrap;

    assign last_col    = (col_reg == COL_W'(COLUMNS - 1));
    assign last_row    = (row_reg == ROW_W'(ROWS - 1));
    assign wraps       = cmd.newline || last_col;
    assign will_scroll = wraps && last_row;

    assign psum     = {1'b0, row_reg} + {1'b0, top_reg};
    assign phys_row = (psum >= (ROW_W + 1)'(ROWS)) ? ROW_W'(psum - (ROW_W + 1)'(ROWS))
                                                   : ROW_W'(psum);

    assign lin_wrap = {1'b0, lin_reg} + (AW + 1)'(COLUMNS) - (AW + 1)'(col_reg);

    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        top_next = top_reg;
        lin_next = lin_reg;
        if (cmd.valid)
        begin
            if (wraps)
            begin
                col_next = '0;
                if (last_row)
                begin
                    // scroll: row stays, top moves down one row
                    top_next = (top_reg == ROW_W'(ROWS - 1)) ? '0 : top_reg + 1'b1;
                    lin_next = lin_reg - AW'(col_reg);
                end
                else
                begin
                    row_next = row_reg + 1'b1;
                    lin_next = AW'(lin_wrap);
                end
            end
            else
            begin
                col_next = col_reg + 1'b1;
                lin_next = lin_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
            top_reg <= '0;
            lin_reg <= '0;
        end
        else
        begin
            row_reg <= row_next;
            col_reg <= col_next;
            top_reg <= top_next;
            lin_reg <= lin_next;
        end
    end

    assign cur_col = col_reg;
    assign top_row = top_reg;
    assign cur_lin = lin_reg;

endmodule

// ===== rtl/core/text_console_writer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer
// text console engine with a scrolling screen of character cells
// ----------------------------------------------------------------------------
// One item at a time. A read or a plain write goes from acceptance through the
// finish state into the result register; a write that scrolls first clears the
// new bottom row one cell per cycle through the single write port of the cell
// memory (scrolling itself only moves a circular top-row pointer). After reset
// the whole memory is cleared, during which no request is taken; configuration
// writes are taken at any time. The result register lets the next request enter
// while a result waits to be taken.
module text_console_writer #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    tcw_req_if.sink      req,
    tcw_rsp_if.source    rsp,
    tcw_cfg_if.sink      cfg
);

    localparam int SIZE  = COLUMNS * ROWS;
    localparam int COL_W = $clog2(COLUMNS);
    localparam int ROW_W = $clog2(ROWS);
    localparam int AW    = $clog2(SIZE);
    localparam int CW    = tcw_pkg::CURSOR_W;
    localparam int DW    = tcw_pkg::ATTR_W + tcw_pkg::CHAR_W;
    localparam logic [AW-1:0] COLS_A = AW'(COLUMNS);

    typedef enum logic [3:0] {
        ST_INIT   = 4'b0001,
        ST_IDLE   = 4'b0010,
        ST_CLEAR  = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [DW-1:0] mem [SIZE];
    logic [DW-1:0] rd_data_reg;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [DW-1:0] mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;

    logic [tcw_pkg::ATTR_W-1:0] attr_reg;

    logic [AW-1:0]    clr_addr_reg, clr_addr_next;
    logic [COL_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic             res_read_reg, res_read_next;
    logic             res_scroll_reg, res_scroll_next;

    logic                         out_valid_reg, out_valid_next;
    logic [CW-1:0]                out_cursor_reg, out_cursor_next;
    logic [tcw_pkg::CHAR_W-1:0]   out_char_reg, out_char_next;
    logic [tcw_pkg::ATTR_W-1:0]   out_attr_reg, out_attr_next;
    logic                         out_scroll_reg, out_scroll_next;

    tcw_pkg::cursor_cmd_t cmd;
    logic [COL_W-1:0]     cur_col;
    logic [ROW_W-1:0]     top_row;
    logic [ROW_W-1:0]     phys_row;
    logic [AW-1:0]        cur_lin;
    logic                 will_scroll;

    logic             accept;
    logic             is_write;
    logic             is_newline;
    logic             in_range;
    logic [ROW_W:0]   rsum;
    logic [ROW_W-1:0] rd_phys_row;
    logic             out_free;

    tcw_cursor #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_cursor (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .cur_col     (cur_col),
        .top_row     (top_row),
        .phys_row    (phys_row),
        .cur_lin     (cur_lin),
        .will_scroll (will_scroll)
    );

    assign req.ready  = (state_reg == ST_IDLE);
    assign accept     = req.valid && req.ready;
    assign is_write   = (req.func == tcw_pkg::FUNC_WRITE);
    assign is_newline = (req.char_code == tcw_pkg::NEWLINE_CODE);

    assign cmd.valid   = accept && is_write;
    assign cmd.newline = is_newline;

    assign in_range    = (int'(req.read_row) < ROWS) && (int'(req.read_col) < COLUMNS);
    assign rsum        = {1'b0, ROW_W'(req.read_row)} + {1'b0, top_row};
    assign rd_phys_row = (rsum >= (ROW_W + 1)'(ROWS)) ? ROW_W'(rsum - (ROW_W + 1)'(ROWS))
                                                      : ROW_W'(rsum);

    assign mem_re    = accept && !is_write;
    assign mem_raddr = AW'(rd_phys_row) * COLS_A + AW'(req.read_col);

    // write port: reset clear, character store, row clear on scroll
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = clr_addr_reg;
        mem_wdata = '0;
        unique case (state_reg)
            ST_INIT, ST_CLEAR:
            begin
                mem_we = 1'b1;
            end
            ST_IDLE:
            begin
                mem_we    = cmd.valid && !is_newline;
                mem_waddr = AW'(phys_row) * COLS_A + AW'(cur_col);
                mem_wdata = {attr_reg, req.char_code};
            end
            ST_FINISH:
            begin
                mem_we = 1'b0;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    assign out_free = !out_valid_reg || rsp.ready;

    always_comb
    begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        clr_cnt_next    = clr_cnt_reg;
        res_read_next   = res_read_reg;
        res_scroll_next = res_scroll_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_cursor_next = out_cursor_reg;
        out_char_next   = out_char_reg;
        out_attr_next   = out_attr_reg;
        out_scroll_next = out_scroll_reg;
        unique case (state_reg)
            ST_INIT:
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == AW'(SIZE - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    res_read_next   = !is_write && in_range;
                    res_scroll_next = is_write && will_scroll;
                    clr_addr_next   = AW'(top_row) * COLS_A;
                    clr_cnt_next    = '0;
                    state_next      = (is_write && will_scroll) ? ST_CLEAR : ST_FINISH;
                end
            end
            ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
                clr_cnt_next  = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == COL_W'(COLUMNS - 1))
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_cursor_next = CW'(cur_lin);
                    out_char_next   = res_read_reg ? rd_data_reg[tcw_pkg::CHAR_W-1:0] : '0;
                    out_attr_next   = res_read_reg ? rd_data_reg[DW-1:tcw_pkg::CHAR_W] : '0;
                    out_scroll_next = res_scroll_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_INIT;
            clr_addr_reg   <= '0;
            clr_cnt_reg    <= '0;
            res_read_reg   <= 1'b0;
            res_scroll_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            attr_reg       <= tcw_pkg::ATTR_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            clr_cnt_reg    <= clr_cnt_next;
            res_read_reg   <= res_read_next;
            res_scroll_reg <= res_scroll_next;
            out_valid_reg  <= out_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                attr_reg <= cfg.data;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        out_cursor_reg <= out_cursor_next;
        out_char_reg   <= out_char_next;
        out_attr_reg   <= out_attr_next;
        out_scroll_reg <= out_scroll_next;
    end

    assign cfg.ready      = 1'b1;
    assign rsp.valid      = out_valid_reg;
    assign rsp.cursor_pos = out_cursor_reg;
    assign rsp.cell_char  = out_char_reg;
    assign rsp.cell_attr  = out_attr_reg;
    assign rsp.scrolled   = out_scroll_reg;

endmodule
